// ===== rtl/spp_pkg.sv =====
package spp_pkg;

    localparam int TABLE_ENTRIES   = 4096;
    localparam int PAGES_PER_BLOCK = 512;

    localparam int ID_W     = 64;
    localparam int IDX_W    = $clog2(TABLE_ENTRIES);
    localparam int TAG_W    = ID_W - IDX_W;
    localparam int PAGE_W   = $clog2(PAGES_PER_BLOCK);
    localparam int WIN_W    = PAGE_W + 1;
    localparam int STRIDE_W = PAGE_W + 1;
    localparam int CALC_W   = WIN_W + 2;
    localparam int CONF_W   = 8;
    localparam int THR_W    = 8;
    localparam int PP_W     = 10;
    localparam int MAXS_W   = 9;

    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 10;

    localparam logic [CFG_IDX_W-1:0] CFG_THRESHOLD  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_PAGES      = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_MAX_STRIDE = 2'd2;

    localparam logic [THR_W-1:0]  THR_RESET  = 8'd2;
    localparam logic [PP_W-1:0]   PP_RESET   = 10'd2;
    localparam logic [MAXS_W-1:0] MAXS_RESET = 9'd128;

    localparam logic [CONF_W-1:0] CONF_MAX = {CONF_W{1'b1}};

    typedef logic [IDX_W-1:0] idx_t;

    typedef struct packed {
        logic [ID_W-1:0]   block_id;
        logic [PAGE_W-1:0] fault_page;
        logic [WIN_W-1:0]  window_first;
        logic [WIN_W-1:0]  window_outer;
    } in_item_t;

    typedef struct packed {
        logic              prefetch_valid;
        logic [WIN_W-1:0]  region_first;
        logic [WIN_W-1:0]  region_outer;
    } out_item_t;

    typedef struct packed {
        logic                valid;
        logic [TAG_W-1:0]    tag;
        logic [PAGE_W-1:0]   prev_page;
        logic [STRIDE_W-1:0] stride;
        logic [CONF_W-1:0]   conf;
    } entry_t;

    typedef struct packed {
        logic   en;
        idx_t   addr;
        entry_t data;
    } tbl_wr_t;

    typedef enum logic [1:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_LOOKUP,
        ST_EMIT
    } state_t;

endpackage

// ===== rtl/spp_table.sv =====
module spp_table (
    input  logic             clk,
    input  spp_pkg::tbl_wr_t wr,
    input  logic             rd_en,
    input  spp_pkg::idx_t    rd_addr,
    output spp_pkg::entry_t  rd_data
);

    spp_pkg::entry_t mem [spp_pkg::TABLE_ENTRIES];

    always_ff @(posedge clk)
    begin
        if (wr.en)
        begin
            mem[wr.addr] <= wr.data;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

// ===== rtl/stride_prefetch_predictor.sv =====
// Stride prefetch predictor. Each fault beat looks up a direct-mapped table indexed by the low
// bits of the block id, learns the page stride of that block and, once the confidence has
// reached the threshold, returns a prefetch region clamped to the window. After reset the
// block sweeps the table once to invalidate every entry, one entry a cycle, and in_ready stays
// low until the sweep is done; configuration writes are taken during the sweep. A fault then
// goes through the table read, the update and write-back, and the region calculation into
// the output register, which waits for the output to be free; the block takes no new beat
// until that last step is done. A finished result may wait in the output register while the
// next beat is accepted.
module stride_prefetch_predictor (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_valid,
    output logic                          in_ready,
    input  spp_pkg::in_item_t             in_data,
    output logic                          out_valid,
    input  logic                          out_ready,
    output spp_pkg::out_item_t            out_data,
    input  logic                          cfg_wr_en,
    input  logic [spp_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [spp_pkg::CFG_DATA_W-1:0] cfg_data
);

    spp_pkg::state_t   state_reg, state_next;
    spp_pkg::idx_t     clr_cnt_reg, clr_cnt_next;
    spp_pkg::in_item_t item_reg;
    logic [spp_pkg::STRIDE_W-1:0] stride_reg;
    logic              issue_reg;
    logic              out_valid_reg, out_valid_next;
    spp_pkg::out_item_t out_data_reg, out_data_next;

    logic [spp_pkg::THR_W-1:0]  thr_reg;
    logic [spp_pkg::PP_W-1:0]   pages_reg;
    logic [spp_pkg::MAXS_W-1:0] max_stride_reg;

    spp_pkg::tbl_wr_t tbl_wr;
    spp_pkg::entry_t  rd_entry;
    logic             in_fire;
    logic             out_free;
    logic             clr_last;

    logic                          id_zero;
    logic                          hit;
    logic signed [spp_pkg::STRIDE_W-1:0] cur;
    logic [spp_pkg::STRIDE_W-1:0]  mag;
    logic                          too_big;
    spp_pkg::entry_t               upd_entry;
    logic                          issue_next;

    logic signed [spp_pkg::CALC_W-1:0] pred;
    logic signed [spp_pkg::CALC_W-1:0] first;
    logic signed [spp_pkg::CALC_W-1:0] outer;
    logic signed [spp_pkg::CALC_W-1:0] pp_ext;
    logic signed [spp_pkg::CALC_W-1:0] wfirst_ext;
    logic signed [spp_pkg::CALC_W-1:0] wouter_ext;

    assign in_fire   = in_valid && in_ready;
    assign out_free  = !out_valid_reg || out_ready;
    assign clr_last  = (clr_cnt_reg == spp_pkg::IDX_W'(spp_pkg::TABLE_ENTRIES - 1));
    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

    spp_table u_table (
        .clk     (clk),
        .wr      (tbl_wr),
        .rd_en   (in_fire),
        .rd_addr (in_data.block_id[spp_pkg::IDX_W-1:0]),
        .rd_data (rd_entry)
    );

    // Next state.
    always_comb
    begin
        state_next   = state_reg;
        clr_cnt_next = clr_cnt_reg;
        case (state_reg)
            spp_pkg::ST_CLEAR:
            begin
                clr_cnt_next = clr_cnt_reg + 1'b1;
                if (clr_last)
                begin
                    state_next = spp_pkg::ST_IDLE;
                end
            end
            spp_pkg::ST_IDLE:
            begin
                if (in_valid)
                begin
                    state_next = spp_pkg::ST_LOOKUP;
                end
            end
            spp_pkg::ST_LOOKUP:
            begin
                state_next = spp_pkg::ST_EMIT;
            end
            spp_pkg::ST_EMIT:
            begin
                if (out_free)
                begin
                    state_next = spp_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = spp_pkg::ST_CLEAR;
            end
        endcase
    end

    // Entry update from the word read out of the table.
    always_comb
    begin
        id_zero   = (item_reg.block_id == '0);
        hit       = rd_entry.valid &&
                    (rd_entry.tag == item_reg.block_id[spp_pkg::ID_W-1:spp_pkg::IDX_W]);
        cur       = $signed({1'b0, item_reg.fault_page}) - $signed({1'b0, rd_entry.prev_page});
        mag       = cur[spp_pkg::STRIDE_W-1] ? spp_pkg::STRIDE_W'(-cur)
                                             : spp_pkg::STRIDE_W'(cur);
        too_big   = (mag > {1'b0, max_stride_reg});
        upd_entry = rd_entry;
        issue_next = 1'b0;
        if (!hit)
        begin
            upd_entry.valid     = 1'b1;
            upd_entry.tag       = item_reg.block_id[spp_pkg::ID_W-1:spp_pkg::IDX_W];
            upd_entry.prev_page = item_reg.fault_page;
            upd_entry.stride    = '0;
            upd_entry.conf      = '0;
        end
        else
        begin
            upd_entry.prev_page = item_reg.fault_page;
            if (cur != '0)
            begin
                if (too_big)
                begin
                    if (rd_entry.conf != '0)
                    begin
                        upd_entry.conf = rd_entry.conf - 1'b1;
                    end
                end
                else
                begin
                    if (cur == $signed(rd_entry.stride))
                    begin
                        if (rd_entry.conf != spp_pkg::CONF_MAX)
                        begin
                            upd_entry.conf = rd_entry.conf + 1'b1;
                        end
                    end
                    else
                    begin
                        if (rd_entry.conf != '0)
                        begin
                            upd_entry.conf = rd_entry.conf - 1'b1;
                        end
                        upd_entry.stride = spp_pkg::STRIDE_W'(cur);
                    end
                    issue_next = (upd_entry.conf >= thr_reg);
                end
            end
        end
        issue_next = issue_next && !id_zero;
    end

    // Table write port: the invalidating sweep, then each write-back, block id zero apart.
    always_comb
    begin
        in_ready     = 1'b0;
        tbl_wr.en    = 1'b0;
        tbl_wr.addr  = clr_cnt_reg;
        tbl_wr.data  = '0;
        case (state_reg)
            spp_pkg::ST_CLEAR:
            begin
                tbl_wr.en = 1'b1;
            end
            spp_pkg::ST_IDLE:
            begin
                in_ready = 1'b1;
            end
            spp_pkg::ST_LOOKUP:
            begin
                tbl_wr.en   = !id_zero;
                tbl_wr.addr = item_reg.block_id[spp_pkg::IDX_W-1:0];
                tbl_wr.data = upd_entry;
            end
            spp_pkg::ST_EMIT:
            begin
                in_ready = 1'b0;
            end
            default:
            begin
                in_ready = 1'b0;
            end
        endcase
    end

    // Region calculation and clamping.
    always_comb
    begin
        pp_ext     = $signed({2'b00, pages_reg});
        wfirst_ext = $signed({2'b00, item_reg.window_first});
        wouter_ext = $signed({2'b00, item_reg.window_outer});
        pred       = $signed({3'b000, item_reg.fault_page}) +
                     spp_pkg::CALC_W'($signed(stride_reg));
        if (!stride_reg[spp_pkg::STRIDE_W-1] && (stride_reg != '0))
        begin
            first = pred;
            outer = pred + pp_ext;
        end
        else
        begin
            first = pred - pp_ext + spp_pkg::CALC_W'(1);
            outer = pred + spp_pkg::CALC_W'(1);
        end
        if (first < wfirst_ext)
        begin
            first = wfirst_ext;
        end
        if (outer > wouter_ext)
        begin
            outer = wouter_ext;
        end
        if (first < 0)
        begin
            first = '0;
        end
        out_data_next = '0;
        if (issue_reg && (first < outer))
        begin
            out_data_next.prefetch_valid = 1'b1;
            out_data_next.region_first   = first[spp_pkg::WIN_W-1:0];
            out_data_next.region_outer   = outer[spp_pkg::WIN_W-1:0];
        end
    end

    always_comb
    begin
        out_valid_next = out_valid_reg && !out_ready;
        if ((state_reg == spp_pkg::ST_EMIT) && out_free)
        begin
            out_valid_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= spp_pkg::ST_CLEAR;
            clr_cnt_reg    <= '0;
            out_valid_reg  <= 1'b0;
            thr_reg        <= spp_pkg::THR_RESET;
            pages_reg      <= spp_pkg::PP_RESET;
            max_stride_reg <= spp_pkg::MAXS_RESET;
        end
        else
        begin
            state_reg     <= state_next;
            clr_cnt_reg   <= clr_cnt_next;
            out_valid_reg <= out_valid_next;
            if (cfg_wr_en)
            begin
                case (cfg_index)
                    spp_pkg::CFG_THRESHOLD:  thr_reg        <= cfg_data[spp_pkg::THR_W-1:0];
                    spp_pkg::CFG_PAGES:      pages_reg      <= cfg_data[spp_pkg::PP_W-1:0];
                    spp_pkg::CFG_MAX_STRIDE: max_stride_reg <= cfg_data[spp_pkg::MAXS_W-1:0];
                    default:                 thr_reg        <= thr_reg;
                endcase
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            item_reg <= in_data;
        end
        if (state_reg == spp_pkg::ST_LOOKUP)
        begin
            stride_reg <= upd_entry.stride;
            issue_reg  <= issue_next;
        end
        if ((state_reg == spp_pkg::ST_EMIT) && out_free)
        begin
            out_data_reg <= out_data_next;
        end
    end

    a_region_ordered: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && out_data.prefetch_valid) |->
            (out_data.region_first < out_data.region_outer))
        else $error("Issued prefetch region is empty or inverted.");

    a_no_region_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !out_data.prefetch_valid) |->
            ((out_data.region_first == '0) && (out_data.region_outer == '0)))
        else $error("Result without a region carries non-zero bounds.");

    a_accept_to_lookup: assert property (@(posedge clk) disable iff (!rst_n)
        in_fire |=> (state_reg == spp_pkg::ST_LOOKUP))
        else $error("Accepted beat did not proceed to the table lookup.");

    a_write_in_idle: assert property (@(posedge clk) disable iff (!rst_n)
        ((state_reg == spp_pkg::ST_IDLE) || (state_reg == spp_pkg::ST_EMIT)) |-> !tbl_wr.en)
        else $error("Table written outside the sweep or the write-back cycle.");

    a_issue_needs_write: assert property (@(posedge clk) disable iff (!rst_n)
        ((state_reg == spp_pkg::ST_LOOKUP) && issue_next) |-> (tbl_wr.en && hit))
        else $error("Region requested without a table hit being written back.");

endmodule
